>>> hdl/wsrpd_pkg.sv
// Package for the wheel speed ramp and PD drive controller: types, codes and microprogram.
`default_nettype none

package wsrpd_pkg;

   // Port widths
   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 120;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_PROP_GAIN   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DERIV_GAIN  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DIST_PER_CT = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_VEL_PER_CT  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TICK_PERIOD = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_PWM_SCALE   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_UPPER_LIMIT = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOWER_LIMIT = 3'd7;

   // Encoder count folding: counts above the wrap point are negative steps
   localparam logic [10:0] ENC_WRAP = 11'd1024;
   localparam logic signed [12:0] ENC_SPAN = 13'sd2049;

   // Microprogram step addresses
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_DIST_MUL  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_SPEED_MUL = 4'd1;
   localparam logic [STEP_W-1:0] STEP_RATE_MUL  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_LEFT      = 4'd3;
   localparam logic [STEP_W-1:0] STEP_DECEL     = 4'd4;
   localparam logic [STEP_W-1:0] STEP_RAMP      = 4'd5;
   localparam logic [STEP_W-1:0] STEP_STEER_MUL = 4'd6;
   localparam logic [STEP_W-1:0] STEP_ERROR     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_PTERM_MUL = 4'd8;
   localparam logic [STEP_W-1:0] STEP_DTERM_MUL = 4'd9;
   localparam logic [STEP_W-1:0] STEP_DTERM_ADD = 4'd10;
   localparam logic [STEP_W-1:0] STEP_CLAMP     = 4'd11;
   localparam logic [STEP_W-1:0] STEP_PWM_MUL   = 4'd12;
   localparam logic [STEP_W-1:0] STEP_DUTY      = 4'd13;
   localparam logic [STEP_W-1:0] STEP_DONE      = 4'd14;
   localparam logic [STEP_W-1:0] STEP_START     = 4'd15;

   // Multiplier operand A select
   typedef enum logic [2:0] {
      OPA_NONE,
      OPA_ENC,
      OPA_PERIOD,
      OPA_RAMP,
      OPA_PGAIN,
      OPA_DGAIN,
      OPA_ACC
   } opa_type;

   // Multiplier operand B select
   typedef enum logic [2:0] {
      OPB_NONE,
      OPB_DPC,
      OPB_VPC,
      OPB_RACC,
      OPB_STEER,
      OPB_E0,
      OPB_DSUM,
      OPB_PWM
   } opb_type;

   // Datapath write-back action
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_TRAV,
      ACT_SPEED,
      ACT_LEFT,
      ACT_DECEL,
      ACT_RAMP,
      ACT_ERR,
      ACT_DSUM,
      ACT_PTERM,
      ACT_DTERM,
      ACT_CLAMP,
      ACT_DUTY,
      ACT_START
   } act_type;

   // Jump condition
   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_ALWAYS,
      JMP_NO_DRIVE
   } jmp_type;

   // One control word
   typedef struct packed {
      logic              mul_en;
      opa_type           opa;
      opb_type           opb;
      act_type           act;
      jmp_type           jmp;
      logic [STEP_W-1:0] target;
      logic              last;
   } ctrl_word_type;

   // Microprogram ROM
   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw.mul_en = 1'b0;
      cw.opa    = OPA_NONE;
      cw.opb    = OPB_NONE;
      cw.act    = ACT_NONE;
      cw.jmp    = JMP_NONE;
      cw.target = STEP_DONE;
      cw.last   = 1'b0;
      case (step)
         STEP_DIST_MUL: begin
            cw.mul_en = 1'b1; cw.opa = OPA_ENC; cw.opb = OPB_DPC;
         end
         STEP_SPEED_MUL: begin
            cw.mul_en = 1'b1; cw.opa = OPA_ENC; cw.opb = OPB_VPC; cw.act = ACT_TRAV;
         end
         STEP_RATE_MUL: begin
            cw.mul_en = 1'b1; cw.opa = OPA_PERIOD; cw.opb = OPB_RACC; cw.act = ACT_SPEED;
         end
         STEP_LEFT:  cw.act = ACT_LEFT;
         STEP_DECEL: cw.act = ACT_DECEL;
         STEP_RAMP:  cw.act = ACT_RAMP;
         STEP_STEER_MUL: begin
            cw.mul_en = 1'b1; cw.opa = OPA_RAMP; cw.opb = OPB_STEER;
         end
         STEP_ERROR: cw.act = ACT_ERR;
         STEP_PTERM_MUL: begin
            cw.mul_en = 1'b1; cw.opa = OPA_PGAIN; cw.opb = OPB_E0; cw.act = ACT_DSUM;
         end
         STEP_DTERM_MUL: begin
            cw.mul_en = 1'b1; cw.opa = OPA_DGAIN; cw.opb = OPB_DSUM; cw.act = ACT_PTERM;
         end
         STEP_DTERM_ADD: begin
            cw.act = ACT_DTERM; cw.jmp = JMP_NO_DRIVE; cw.target = STEP_DONE;
         end
         STEP_CLAMP: cw.act = ACT_CLAMP;
         STEP_PWM_MUL: begin
            cw.mul_en = 1'b1; cw.opa = OPA_ACC; cw.opb = OPB_PWM;
         end
         STEP_DUTY: cw.act = ACT_DUTY;
         STEP_DONE: cw.last = 1'b1;
         STEP_START: begin
            cw.act = ACT_START; cw.jmp = JMP_ALWAYS; cw.target = STEP_DONE;
         end
         default: cw.last = 1'b1;
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

>>> hdl/wheel_speed_ramp_pd_controller.sv
// Wheel speed ramp and PD drive controller: one wheel channel, microcoded over one multiplier.
`default_nettype none

// One wheel channel of a trapezoidal speed profile with a PD speed loop. A transfer with
// req_tuser high loads a new move; with req_tuser low it is one control tick that folds the
// encoder count into travel and speed, ramps the setpoint, runs the PD loop and, when the
// drive is enabled, gives PWM duty and direction. Each item gives exactly one result. The
// work runs as a microprogram from a small ROM over a single 33 x 33 bit signed multiplier
// with a registered product, so one step is one cycle and items are handled one at a time.
// A tick with the drive disabled skips the clamp, PWM and duty steps, and a move start runs
// only its start step; a result left waiting on rsp_tready stalls the last step. Registers
// must be written on the csr port only while the block is idle; it does not enforce this.
module wheel_speed_ramp_pd_controller
   import wsrpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // tdata, low bit up: encoder_count[10:0], steer_factor[28:11], drive_enable[29],
   // move_distance[61:30], slow_distance[92:62], cruise_speed[124:93],
   // final_speed[156:125], acceleration[187:157], zero fill
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,   // command
   // tdata, low bit up: pwm_duty[15:0], forward[16], drive_valid[17],
   // measured_speed[49:18], set_speed[81:50], distance_left[113:82], decel_armed[114],
   // zero fill
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [31:0] kp_ff, kp_in, kd_ff, kd_in, lower_ff, lower_in;
   logic [30:0] dpc_ff, dpc_in, vpc_ff, vpc_in, period_ff, period_in;
   logic [30:0] pwm_scale_ff, pwm_scale_in, upper_ff, upper_in;

   // Sequencer control
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] pc_ff, pc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ctrl_word_type     cw;
   logic              hold, go, accept;
   act_type           act_go;

   // Channel state
   logic [31:0] prev_ff, prev_in, ramp_ff, ramp_in, goal_ff, goal_in;
   logic [31:0] slow_speed_ff, slow_speed_in, goal_dist_ff, goal_dist_in;
   logic [30:0] slow_point_ff, slow_point_in, racc_ff, racc_in;
   logic [31:0] travel_ff, travel_in, acc_ff, acc_in;
   logic        decel_ff, decel_in;
   logic [31:0] hist_ff [4];
   logic [31:0] hist_in [4];

   // Working and payload registers
   logic [REQ_DATA_W-1:0] req_data_ff, req_data_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic signed [65:0]    prod_ff, prod_in;
   logic [31:0] dsum_ff, dsum_in, avg_ff, avg_in, left_ff, left_in;
   logic [15:0] duty_ff, duty_in;
   logic        fwd_ff, fwd_in, valid_ff, valid_in;

   // Datapath nets
   logic [10:0]        enc;
   logic [17:0]        steer;
   logic               drive_en;
   logic signed [12:0] enc_step;
   logic signed [32:0] opa, opb;
   logic signed [65:0] mul_res;
   logic [31:0]        trav_step, sample, hi_word, q15_word, hi_neg, speed_sum, mag, err0;
   logic signed [33:0] r_ext, g_ext, up_sum, dn_sum;
   logic [31:0]        ramp_next;

   // Control word and handshake
   assign cw         = ucode_rom(pc_ff);
   assign hold       = cw.last && rsp_valid_ff && !rsp_tready;
   assign go         = busy_ff && !hold;
   assign act_go     = go ? cw.act : ACT_NONE;
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Latched tick fields
   assign enc      = req_data_ff[10:0];
   assign steer    = req_data_ff[28:11];
   assign drive_en = req_data_ff[29];
   assign enc_step = (enc > ENC_WRAP) ? ($signed({2'b00, enc}) - ENC_SPAN)
                                      : $signed({2'b00, enc});

   // Operand selection
   always_comb begin
      case (cw.opa)
         OPA_ENC:    opa = {{20{enc_step[12]}}, enc_step};
         OPA_PERIOD: opa = {2'b00, period_ff};
         OPA_RAMP:   opa = {ramp_ff[31], ramp_ff};
         OPA_PGAIN:  opa = {kp_ff[31], kp_ff};
         OPA_DGAIN:  opa = {kd_ff[31], kd_ff};
         OPA_ACC:    opa = {acc_ff[31], acc_ff};
         default:    opa = '0;
      endcase
      case (cw.opb)
         OPB_DPC:   opb = {2'b00, dpc_ff};
         OPB_VPC:   opb = {2'b00, vpc_ff};
         OPB_RACC:  opb = {2'b00, racc_ff};
         OPB_STEER: opb = {15'd0, steer};
         OPB_E0:    opb = {hist_ff[0][31], hist_ff[0]};
         OPB_DSUM:  opb = {dsum_ff[31], dsum_ff};
         OPB_PWM:   opb = {2'b00, pwm_scale_ff};
         default:   opb = '0;
      endcase
   end

   assign mul_res = opa * opb;

   // Product slices
   assign trav_step = {{10{prod_ff[36]}}, prod_ff[36:15]};
   assign sample    = prod_ff[40:9];
   assign hi_word   = prod_ff[61:30];
   assign q15_word  = prod_ff[46:15];
   assign hi_neg    = 32'd0 - hi_word;
   assign speed_sum = sample + prev_ff;
   assign mag       = left_ff[31] ? (32'd0 - left_ff) : left_ff;
   assign err0      = q15_word - avg_ff;

   // Ramp toward the goal by one step, stopping at the goal
   assign r_ext  = {{2{ramp_ff[31]}}, ramp_ff};
   assign g_ext  = {{2{goal_ff[31]}}, goal_ff};
   assign up_sum = r_ext + $signed({2'b00, hi_word});
   assign dn_sum = r_ext - $signed({2'b00, hi_word});
   always_comb begin
      if (g_ext > r_ext) begin
         ramp_next = (up_sum > g_ext) ? goal_ff : up_sum[31:0];
      end else if (g_ext < r_ext) begin
         ramp_next = (dn_sum < g_ext) ? goal_ff : dn_sum[31:0];
      end else begin
         ramp_next = ramp_ff;
      end
   end

   // Next values
   always_comb begin
      kp_in = kp_ff; kd_in = kd_ff; dpc_in = dpc_ff; vpc_in = vpc_ff;
      period_in = period_ff; pwm_scale_in = pwm_scale_ff;
      upper_in = upper_ff; lower_in = lower_ff;
      busy_in = busy_ff; pc_in = pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      prev_in = prev_ff; ramp_in = ramp_ff; goal_in = goal_ff;
      slow_speed_in = slow_speed_ff; goal_dist_in = goal_dist_ff;
      slow_point_in = slow_point_ff; racc_in = racc_ff;
      travel_in = travel_ff; acc_in = acc_ff; decel_in = decel_ff;
      hist_in = hist_ff;
      req_data_in = req_data_ff; rsp_data_in = rsp_data_ff;
      prod_in = prod_ff; dsum_in = dsum_ff; avg_in = avg_ff; left_in = left_ff;
      duty_in = duty_ff; fwd_in = fwd_ff; valid_in = valid_ff;

      // Register writes
      if (csr_we) begin
         case (csr_addr)
            CSR_PROP_GAIN:   kp_in        = csr_wdata;
            CSR_DERIV_GAIN:  kd_in        = csr_wdata;
            CSR_DIST_PER_CT: dpc_in       = csr_wdata[30:0];
            CSR_VEL_PER_CT:  vpc_in       = csr_wdata[30:0];
            CSR_TICK_PERIOD: period_in    = csr_wdata[30:0];
            CSR_PWM_SCALE:   pwm_scale_in = csr_wdata[30:0];
            CSR_UPPER_LIMIT: upper_in     = csr_wdata[30:0];
            CSR_LOWER_LIMIT: lower_in     = csr_wdata;
            default: ;
         endcase
      end

      // Accept: latch the item, clear per-item outputs, dispatch
      if (accept) begin
         req_data_in = req_tdata;
         busy_in     = 1'b1;
         pc_in       = req_tuser ? STEP_START : STEP_DIST_MUL;
         duty_in     = '0;
         fwd_in      = 1'b0;
         valid_in    = 1'b0;
         avg_in      = '0;
      end

      // Step sequencing
      if (go) begin
         if (cw.last) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = {5'd0, decel_ff, left_ff, ramp_ff, avg_ff,
                            valid_ff, fwd_ff, duty_ff};
         end else if (cw.jmp == JMP_ALWAYS || (cw.jmp == JMP_NO_DRIVE && !drive_en)) begin
            pc_in = cw.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
         if (cw.mul_en) begin
            prod_in = mul_res;
         end
      end

      // Datapath actions
      case (act_go)
         ACT_TRAV: travel_in = travel_ff + trav_step;
         ACT_SPEED: begin
            avg_in  = {speed_sum[31], speed_sum[31:1]};
            prev_in = sample;
         end
         ACT_LEFT: left_in = goal_dist_ff - travel_ff;
         ACT_DECEL: begin
            if (decel_ff && ({1'b0, slow_point_ff} >= mag)) begin
               goal_in  = slow_speed_ff;
               decel_in = 1'b0;
            end
         end
         ACT_RAMP: ramp_in = ramp_next;
         ACT_ERR: begin
            hist_in[0] = err0;
            hist_in[1] = hist_ff[0];
            hist_in[2] = hist_ff[1];
            hist_in[3] = hist_ff[2];
         end
         ACT_DSUM: dsum_in = ((hist_ff[0] - hist_ff[3]) + (hist_ff[1] - hist_ff[2])) << 1;
         ACT_PTERM, ACT_DTERM: acc_in = acc_ff + q15_word;
         ACT_CLAMP: begin
            if ($signed(acc_ff) > 32'sd0) begin
               if ($signed(acc_ff) > $signed({1'b0, upper_ff})) begin
                  acc_in = {1'b0, upper_ff};
               end
               fwd_in = 1'b1;
            end else if ($signed(acc_ff) < $signed(lower_ff)) begin
               acc_in = lower_ff;
            end
         end
         ACT_DUTY: begin
            duty_in  = fwd_ff ? hi_word[30:15] : hi_neg[30:15];
            valid_in = 1'b1;
         end
         ACT_START: begin
            goal_dist_in  = req_data_ff[61:30];
            slow_point_in = req_data_ff[92:62];
            goal_in       = req_data_ff[124:93];
            slow_speed_in = req_data_ff[156:125];
            racc_in       = req_data_ff[187:157];
            decel_in      = 1'b1;
            travel_in     = '0;
            left_in       = req_data_ff[61:30];
         end
         default: ;
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0; kd_ff <= '0; dpc_ff <= '0; vpc_ff <= '0;
         period_ff <= '0; pwm_scale_ff <= '0; upper_ff <= '0; lower_ff <= '0;
         busy_ff <= 1'b0; pc_ff <= STEP_DIST_MUL; rsp_valid_ff <= 1'b0;
         prev_ff <= '0; ramp_ff <= '0; goal_ff <= '0; slow_speed_ff <= '0;
         goal_dist_ff <= '0; slow_point_ff <= '0; racc_ff <= '0;
         travel_ff <= '0; acc_ff <= '0; decel_ff <= 1'b0;
         hist_ff[0] <= '0; hist_ff[1] <= '0; hist_ff[2] <= '0; hist_ff[3] <= '0;
      end else begin
         kp_ff <= kp_in; kd_ff <= kd_in; dpc_ff <= dpc_in; vpc_ff <= vpc_in;
         period_ff <= period_in; pwm_scale_ff <= pwm_scale_in;
         upper_ff <= upper_in; lower_ff <= lower_in;
         busy_ff <= busy_in; pc_ff <= pc_in; rsp_valid_ff <= rsp_valid_in;
         prev_ff <= prev_in; ramp_ff <= ramp_in; goal_ff <= goal_in;
         slow_speed_ff <= slow_speed_in; goal_dist_ff <= goal_dist_in;
         slow_point_ff <= slow_point_in; racc_ff <= racc_in;
         travel_ff <= travel_in; acc_ff <= acc_in; decel_ff <= decel_in;
         hist_ff <= hist_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= prod_in;
      dsum_ff     <= dsum_in;
      avg_ff      <= avg_in;
      left_ff     <= left_in;
      duty_ff     <= duty_in;
      fwd_ff      <= fwd_in;
      valid_ff    <= valid_in;
   end

`ifndef SYNTHESIS
   // An accepted transfer starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> busy_ff)
      else $error("sequencer not started after accepted transfer");

   // Forward direction only comes with a driven result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[16]) |-> rsp_tdata[17])
      else $error("forward set without drive_valid");

   // The deceleration flag only clears at the slowdown check
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(decel_ff)) |-> $past(act_go == ACT_DECEL))
      else $error("decel flag cleared outside the slowdown check");

   // A result is only issued from the final step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc_ff == STEP_DONE))
      else $error("result issued outside the final step");
`endif

endmodule

`default_nettype wire
